@@ sv/ycr_pkg.sv @@
// Shared types, constants and the round-and-clamp function for the YCbCr to RGB converter.
`default_nettype none

package ycr_pkg;

  // Fixed-point format of the weights and the chroma zero level
  localparam int FRACTION_BITS = 6;
  localparam int CHROMA_ZERO   = 128;
  localparam int CHANNEL_MAX   = 255;

  // Field, register-index and arithmetic widths
  localparam int CHAN_W  = 8;
  localparam int GAIN_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int DIFF_W  = CHAN_W + 1;          // offset-removed component, signed
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;  // signed gain times signed component
  localparam int SUM_W   = PROD_W + 2;           // sum of up to three products

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRACTION_BITS - 1));

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_GAIN_RED    = 3'd0,
    REG_CR_GAIN_RED      = 3'd1,
    REG_LUMA_GAIN_GREEN  = 3'd2,
    REG_CB_GAIN_GREEN    = 3'd3,
    REG_CR_GAIN_GREEN    = 3'd4,
    REG_LUMA_GAIN_BLUE   = 3'd5,
    REG_CB_GAIN_BLUE     = 3'd6,
    REG_LUMA_BLACK_LEVEL = 3'd7
  } cfg_reg_t;

  // One input item
  typedef struct packed {
    logic [CHAN_W-1:0] luma;
    logic [CHAN_W-1:0] chroma_blue;
    logic [CHAN_W-1:0] chroma_red;
  } pixel_in_t;

  // One result item
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_out_t;

  // Register file contents
  typedef struct packed {
    logic [GAIN_W-1:0] luma_gain_red;
    logic [GAIN_W-1:0] cr_gain_red;
    logic [GAIN_W-1:0] luma_gain_green;
    logic [GAIN_W-1:0] cb_gain_green;
    logic [GAIN_W-1:0] cr_gain_green;
    logic [GAIN_W-1:0] luma_gain_blue;
    logic [GAIN_W-1:0] cb_gain_blue;
    logic [CHAN_W-1:0] luma_black_level;
  } conv_cfg_t;

  // Add half an LSB, shift out the fraction and clamp to the channel range
  function automatic logic [CHAN_W-1:0] finish_channel(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] biased;
    logic [SUM_W-1:0]        shifted;
    logic [CHAN_W-1:0]       res;
    biased  = sum + $signed(ROUND_HALF);
    shifted = SUM_W'(biased >>> FRACTION_BITS);
    if (biased[SUM_W-1]) begin
      res = '0;
    end else if (shifted > SUM_W'(CHANNEL_MAX)) begin
      res = CHAN_W'(CHANNEL_MAX);
    end else begin
      res = shifted[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/ycr_convert.sv @@
// Combinational colour matrix: offset removal, weighted sums, rounding and clamping.
`default_nettype none

module ycr_convert (
  input  wire ycr_pkg::conv_cfg_t  cfg,
  input  wire ycr_pkg::pixel_in_t  pix_in,
  output ycr_pkg::pixel_out_t      pix_out
);
  import ycr_pkg::*;

  logic signed [DIFF_W-1:0] y_d;
  logic signed [DIFF_W-1:0] cb_d;
  logic signed [DIFF_W-1:0] cr_d;

  logic signed [PROD_W-1:0] p_y_r, p_cr_r, p_y_g, p_cb_g, p_cr_g, p_y_b, p_cb_b;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;

  // Remove the black level and the chroma zero
  always_comb begin
    y_d  = $signed({1'b0, pix_in.luma}) - $signed({1'b0, cfg.luma_black_level});
    cb_d = $signed({1'b0, pix_in.chroma_blue}) - $signed(DIFF_W'(CHROMA_ZERO));
    cr_d = $signed({1'b0, pix_in.chroma_red}) - $signed(DIFF_W'(CHROMA_ZERO));
  end

  // Weight each component
  always_comb begin
    p_y_r  = PROD_W'($signed({1'b0, cfg.luma_gain_red})   * y_d);
    p_cr_r = PROD_W'($signed({1'b0, cfg.cr_gain_red})     * cr_d);
    p_y_g  = PROD_W'($signed({1'b0, cfg.luma_gain_green}) * y_d);
    p_cb_g = PROD_W'($signed({1'b0, cfg.cb_gain_green})   * cb_d);
    p_cr_g = PROD_W'($signed({1'b0, cfg.cr_gain_green})   * cr_d);
    p_y_b  = PROD_W'($signed({1'b0, cfg.luma_gain_blue})  * y_d);
    p_cb_b = PROD_W'($signed({1'b0, cfg.cb_gain_blue})    * cb_d);
  end

  // Sum per channel, then round and clamp
  always_comb begin
    sum_r = SUM_W'(p_y_r) + SUM_W'(p_cr_r);
    sum_g = SUM_W'(p_y_g) - SUM_W'(p_cb_g) - SUM_W'(p_cr_g);
    sum_b = SUM_W'(p_y_b) + SUM_W'(p_cb_b);
    pix_out.red   = finish_channel(sum_r);
    pix_out.green = finish_channel(sum_g);
    pix_out.blue  = finish_channel(sum_b);
  end

endmodule

`default_nettype wire

@@ sv/ycbcr_to_rgb_studio_unit.sv @@
// Top level of the studio-range YCbCr to RGB converter: registers, handshake and pipeline.
`default_nettype none

//  channel | direction | signals                           | payload
//  --------+-----------+-----------------------------------+-------------------------
//  in      | input     | in_valid, in_stall, in_data       | luma, chroma_blue, chroma_red
//  out     | output    | out_valid, out_stall, out_data    | red, green, blue
//  cfg     | input     | cfg_wr_en, cfg_index, cfg_data    | one 8-bit register per write
//
//  Input register, then matrix logic into the result register. One item per cycle
//  sustained while out_stall is low; the multiply-add-clamp path between the two
//  registers sets the clock. Reset (rst_n, synchronous) empties both stages and loads
//  the default weights. Under out_stall, a bubble in the input stage is still filled;
//  in_stall rises only when both stages hold an item and the result is stalled.

module ycbcr_to_rgb_studio_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire ycr_pkg::pixel_in_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output ycr_pkg::pixel_out_t          out_data,
  input  wire                          cfg_wr_en,
  input  wire [ycr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [ycr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ycr_pkg::*;

  conv_cfg_t  cfg_r;
  pixel_in_t  s1_data_r;
  logic       s1_valid_r;
  pixel_out_t s2_data_r;
  logic       s2_valid_r;
  pixel_out_t conv_out;
  logic       s2_load;
  logic       s1_load;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_gain_red    <= 8'd75;
      cfg_r.cr_gain_red      <= 8'd115;
      cfg_r.luma_gain_green  <= 8'd75;
      cfg_r.cb_gain_green    <= 8'd14;
      cfg_r.cr_gain_green    <= 8'd34;
      cfg_r.luma_gain_blue   <= 8'd75;
      cfg_r.cb_gain_blue     <= 8'd135;
      cfg_r.luma_black_level <= 8'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LUMA_GAIN_RED:    cfg_r.luma_gain_red    <= cfg_data;
        REG_CR_GAIN_RED:      cfg_r.cr_gain_red      <= cfg_data;
        REG_LUMA_GAIN_GREEN:  cfg_r.luma_gain_green  <= cfg_data;
        REG_CB_GAIN_GREEN:    cfg_r.cb_gain_green    <= cfg_data;
        REG_CR_GAIN_GREEN:    cfg_r.cr_gain_green    <= cfg_data;
        REG_LUMA_GAIN_BLUE:   cfg_r.luma_gain_blue   <= cfg_data;
        REG_CB_GAIN_BLUE:     cfg_r.cb_gain_blue     <= cfg_data;
        REG_LUMA_BLACK_LEVEL: cfg_r.luma_black_level <= cfg_data;
        default:              cfg_r <= cfg_r;
      endcase
    end
  end

  // Advance the result stage when it is empty or being taken; fill the input stage likewise
  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  // Hold or advance the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  ycr_convert u_convert (
    .cfg     (cfg_r),
    .pix_in  (s1_data_r),
    .pix_out (conv_out)
  );

  // Hold or advance the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_data_r <= conv_out;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

`default_nettype wire
